// ===== rtl/pes_pkg.sv =====
`default_nettype none

package pes_pkg;

    localparam int CUBE_SIDE      = 16;
    localparam int WORD_BITS      = 64;
    localparam int MAX_ENTRY_BITS = 8;

    localparam int COORD_W      = $clog2(CUBE_SIDE);
    localparam int LIN_W        = 3 * COORD_W;
    localparam int CUBE_ENTRIES = CUBE_SIDE * CUBE_SIDE * CUBE_SIDE;
    localparam int STORE_WORDS  = (CUBE_ENTRIES * MAX_ENTRY_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W       = $clog2(STORE_WORDS);
    localparam int OFF_W        = $clog2(WORD_BITS);
    localparam int BITS_W       = 4;
    localparam int VAL_W        = 8;
    localparam int POS_W        = LIN_W + BITS_W;

    localparam logic [BITS_W-1:0] ENTRY_BITS_RESET = BITS_W'(4);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD0,
        S_MOD0,
        S_RD1,
        S_MOD1,
        S_DONE
    } t_pes_state;

    typedef struct packed {
        logic clr_we;
        logic load_in;
        logic rd_w0;
        logic mod0;
        logic rd_w1;
        logic mod1;
        logic load_out;
    } t_pes_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_write;
        logic straddle;
        logic out_free;
    } t_pes_sts;

endpackage

`default_nettype wire

// ===== rtl/pes_ctrl.sv =====
`default_nettype none

module pes_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  pes_pkg::t_pes_sts i_sts,
    output logic              o_in_ready,
    output pes_pkg::t_pes_cmd o_cmd
);

    pes_pkg::t_pes_state r_state;
    pes_pkg::t_pes_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pes_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            pes_pkg::S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = pes_pkg::S_IDLE;
                end
            end
            pes_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = pes_pkg::S_RD0;
                end
            end
            pes_pkg::S_RD0: begin
                o_cmd.rd_w0 = 1'b1;
                n_state     = pes_pkg::S_MOD0;
            end
            pes_pkg::S_MOD0: begin
                o_cmd.mod0 = 1'b1;
                if (i_sts.straddle) begin
                    n_state = pes_pkg::S_RD1;
                end else if (i_sts.is_write) begin
                    n_state = pes_pkg::S_IDLE;
                end else begin
                    n_state = pes_pkg::S_DONE;
                end
            end
            pes_pkg::S_RD1: begin
                o_cmd.rd_w1 = 1'b1;
                n_state     = pes_pkg::S_MOD1;
            end
            pes_pkg::S_MOD1: begin
                o_cmd.mod1 = 1'b1;
                if (i_sts.is_write) begin
                    n_state = pes_pkg::S_IDLE;
                end else begin
                    n_state = pes_pkg::S_DONE;
                end
            end
            pes_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = pes_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pes_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/pes_dpath.sv =====
`default_nettype none

module pes_dpath (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  pes_pkg::t_pes_cmd                  i_cmd,
    output pes_pkg::t_pes_sts                  o_sts,
    input  wire                                i_cfg_valid,
    input  wire  [pes_pkg::BITS_W-1:0]         i_cfg_data,
    input  wire                                i_command,
    input  wire  [3:0]                         i_pos_x,
    input  wire  [3:0]                         i_pos_y,
    input  wire  [3:0]                         i_pos_z,
    input  wire  [pes_pkg::VAL_W-1:0]          i_write_value,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [pes_pkg::VAL_W-1:0]          o_entry_value
);

    localparam int WB = pes_pkg::WORD_BITS;

    logic [pes_pkg::BITS_W-1:0] r_entry_bits;
    logic [WB-1:0]              r_mem [pes_pkg::STORE_WORDS];
    logic [WB-1:0]              r_rd;
    logic [WB-1:0]              r_lo;
    logic [pes_pkg::ADDR_W-1:0] r_clr_cnt;
    logic [pes_pkg::ADDR_W-1:0] r_w0;
    logic [pes_pkg::OFF_W-1:0]  r_off;
    logic                       r_straddle;
    logic                       r_is_wr;
    logic [pes_pkg::VAL_W-1:0]  r_mask;
    logic [pes_pkg::VAL_W-1:0]  r_wval;
    logic [pes_pkg::VAL_W-1:0]  r_rslt;
    logic                       r_out_valid;
    logic [pes_pkg::VAL_W-1:0]  r_out_val;

    logic [pes_pkg::BITS_W-1:0] eff_bits;
    logic [pes_pkg::VAL_W-1:0]  mask;
    logic [pes_pkg::LIN_W-1:0]  lin;
    logic [pes_pkg::POS_W-1:0]  bitpos;
    logic [pes_pkg::OFF_W:0]    end_pos;
    logic [2*WB-1:0]            field_mask;
    logic [2*WB-1:0]            field_val;
    logic [2*WB-1:0]            gather;
    logic [WB-1:0]              lo_shift;
    logic [pes_pkg::ADDR_W-1:0] mem_addr;
    logic                       mem_we;
    logic                       mem_re;
    logic [WB-1:0]              mem_wdata;

    // Widths above the maximum saturate; the mask covers the effective width.
    always_comb begin
        if (r_entry_bits > pes_pkg::BITS_W'(pes_pkg::MAX_ENTRY_BITS)) begin
            eff_bits = pes_pkg::BITS_W'(pes_pkg::MAX_ENTRY_BITS);
        end else begin
            eff_bits = r_entry_bits;
        end
        mask    = pes_pkg::VAL_W'((9'd1 << eff_bits) - 9'd1);
        lin     = {i_pos_y[pes_pkg::COORD_W-1:0], i_pos_z[pes_pkg::COORD_W-1:0],
                   i_pos_x[pes_pkg::COORD_W-1:0]};
        bitpos  = pes_pkg::POS_W'(lin) * pes_pkg::POS_W'(eff_bits);
        end_pos = (pes_pkg::OFF_W + 1)'(bitpos[pes_pkg::OFF_W-1:0])
                  + (pes_pkg::OFF_W + 1)'(eff_bits);
    end

    assign field_mask = (2 * WB)'(r_mask) << r_off;
    assign field_val  = (2 * WB)'(r_wval) << r_off;
    assign gather     = {r_rd, r_lo} >> r_off;
    assign lo_shift   = r_rd >> r_off;

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = r_w0;
        mem_wdata = '0;
        if (i_cmd.clr_we) begin
            mem_we   = 1'b1;
            mem_addr = r_clr_cnt;
        end else if (i_cmd.rd_w0) begin
            mem_re = 1'b1;
        end else if (i_cmd.mod0) begin
            mem_we    = r_is_wr;
            mem_wdata = (r_rd & ~field_mask[WB-1:0]) | field_val[WB-1:0];
        end else if (i_cmd.rd_w1) begin
            mem_re   = 1'b1;
            mem_addr = r_w0 + pes_pkg::ADDR_W'(1);
        end else if (i_cmd.mod1) begin
            mem_we    = r_is_wr;
            mem_addr  = r_w0 + pes_pkg::ADDR_W'(1);
            mem_wdata = (r_rd & ~field_mask[2*WB-1:WB]) | field_val[2*WB-1:WB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_bits <= pes_pkg::ENTRY_BITS_RESET;
            r_clr_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_entry_bits <= i_cfg_data;
            end
            if (i_cmd.clr_we) begin
                r_clr_cnt <= r_clr_cnt + pes_pkg::ADDR_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_w0       <= bitpos[pes_pkg::OFF_W +: pes_pkg::ADDR_W];
            r_off      <= bitpos[pes_pkg::OFF_W-1:0];
            r_straddle <= end_pos > (pes_pkg::OFF_W + 1)'(WB);
            r_is_wr    <= i_command;
            r_mask     <= mask;
            r_wval     <= i_write_value & mask;
        end
        if (i_cmd.mod0) begin
            r_lo   <= r_rd;
            r_rslt <= lo_shift[pes_pkg::VAL_W-1:0] & r_mask;
        end
        if (i_cmd.mod1) begin
            r_rslt <= gather[pes_pkg::VAL_W-1:0] & r_mask;
        end
        if (i_cmd.load_out) begin
            r_out_val <= r_rslt;
        end
    end

    assign o_sts.clr_last = (r_clr_cnt == pes_pkg::ADDR_W'(pes_pkg::STORE_WORDS - 1));
    assign o_sts.is_write = r_is_wr;
    assign o_sts.straddle = r_straddle;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_entry_value = r_out_val;

endmodule

`default_nettype wire

// ===== rtl/packed_entry_store.sv =====
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        input      i_in_valid/o_in_ready   i_command, i_pos_x, i_pos_y, i_pos_z,
//                                              i_write_value
// out       output     o_out_valid/i_out_ready o_entry_value
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_data
//
// An item makes its memory accesses one after another on the single-port word store:
// an entry inside one word passes S_IDLE (the accept), S_RD0 and S_MOD0, and one
// that straddles two words goes on through S_RD1 and S_MOD1; a read then loads
// the output register in S_DONE. After reset the store is cleared one word per
// cycle, all 512 words, during which no item is accepted. A finished read waits in the
// output register while the next item is taken; a stalled output holds the block
// only when a second read result is ready.

module packed_entry_store (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire                               i_command,
    input  wire  [3:0]                        i_pos_x,
    input  wire  [3:0]                        i_pos_y,
    input  wire  [3:0]                        i_pos_z,
    input  wire  [pes_pkg::VAL_W-1:0]         i_write_value,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [pes_pkg::VAL_W-1:0]         o_entry_value,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [pes_pkg::BITS_W-1:0]        i_cfg_data
);

    pes_pkg::t_pes_cmd cmd;
    pes_pkg::t_pes_sts sts;

    assign o_cfg_ready = 1'b1;

    pes_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    pes_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_command     (i_command),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_write_value (i_write_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_entry_value (o_entry_value)
    );

endmodule

`default_nettype wire
